// ===== rtl/core/kmd_pkg.sv =====
// Shared types and constants of the key matrix debounce and event block.
package kmd_pkg;

  localparam int RowW    = 3;
  localparam int ColW    = 8;
  localparam int MaxRows = 8;
  localparam int MaxCols = 8;
  localparam int DbW     = 16;

  localparam int DefRows     = 8;
  localparam int DefCols     = 8;
  localparam int QueueDepth  = 2;

  localparam logic [DbW-1:0] DebounceReset = 16'd5;

  localparam logic KindSample = 1'b0;
  localparam logic KindTick   = 1'b1;

  typedef logic [RowW-1:0] row_idx_t;
  typedef logic [ColW-1:0] col_vec_t;
  typedef logic [2:0]      col_idx_t;

  typedef struct packed {
    logic     kind;
    row_idx_t row_index;
    col_vec_t column_bits;
  } in_item_t;

  typedef struct packed {
    row_idx_t event_row;
    col_idx_t event_column;
    logic     pressed;
    logic     last;
  } out_item_t;

  // One row of a commit that has at least one changed key.
  typedef struct packed {
    row_idx_t row;
    col_vec_t diff;
    col_vec_t level;
    logic     last_row;
  } row_entry_t;

endpackage

// ===== rtl/core/kmd_front.sv =====
// Front part: takes samples and ticks, keeps the matrices and walks rows on a commit.
module kmd_front #(
  parameter int ROWS = kmd_pkg::DefRows,
  parameter int COLS = kmd_pkg::DefCols
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kmd_pkg::in_item_t    in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  output logic                 push_valid,
  input  logic                 push_full,
  output kmd_pkg::row_entry_t  push_data
);

  localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SCAN = 3'b010,
    F_WALK = 3'b100
  } front_state_t;

  front_state_t     state_r, state_nxt;
  logic [COLS-1:0]  raw_r    [ROWS];
  logic [COLS-1:0]  stable_r [ROWS];
  logic             pend_r, pend_nxt;
  logic [15:0]      hold_r, hold_nxt;
  logic [15:0]      debounce_r;
  logic [ROWS-1:0]  dirty_r, dirty_nxt;
  logic [RIW-1:0]   row_r, row_nxt;

  logic             accept;
  logic             row_ok;
  logic [RIW-1:0]   ridx;
  logic [COLS-1:0]  cols;
  logic             raw_we;
  logic             stable_we;
  logic [ROWS-1:0]  row_onehot;
  logic [COLS-1:0]  walk_diff;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state_r != F_IDLE);
  assign accept     = in_valid && !in_stall;
  assign row_ok     = ({1'b0, in_data.row_index} < 4'(ROWS));
  assign ridx       = in_data.row_index[RIW-1:0];
  assign cols       = in_data.column_bits[COLS-1:0];
  assign row_onehot = ROWS'(1) << row_r;
  assign walk_diff  = raw_r[row_r] ^ stable_r[row_r];

  assign push_data.row      = kmd_pkg::row_idx_t'(row_r);
  assign push_data.diff     = kmd_pkg::col_vec_t'(walk_diff);
  assign push_data.level    = kmd_pkg::col_vec_t'(raw_r[row_r]);
  assign push_data.last_row = ((dirty_r & ~row_onehot) == '0);

  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    hold_nxt   = hold_r;
    dirty_nxt  = dirty_r;
    row_nxt    = row_r;
    raw_we     = 1'b0;
    stable_we  = 1'b0;
    push_valid = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_data.kind == kmd_pkg::KindSample) begin
            if (row_ok && (raw_r[ridx] != cols)) begin
              raw_we   = 1'b1;
              pend_nxt = 1'b1;
              hold_nxt = debounce_r;
            end
          end else if (hold_r != 16'd0) begin
            hold_nxt = hold_r - 16'd1;
          end
          if (pend_nxt && (hold_nxt == 16'd0)) begin
            pend_nxt  = 1'b0;
            state_nxt = F_SCAN;
          end
        end
      end
      F_SCAN: begin
        for (int r = 0; r < ROWS; r++) begin
          dirty_nxt[r] = |(raw_r[r] ^ stable_r[r]);
        end
        row_nxt   = '0;
        state_nxt = F_WALK;
      end
      F_WALK: begin
        push_valid = dirty_r[row_r] && !push_full;
        if (!dirty_r[row_r] || !push_full) begin
          stable_we = 1'b1;
          dirty_nxt = dirty_r & ~row_onehot;
          if (row_r == RIW'(ROWS - 1)) begin
            state_nxt = F_IDLE;
          end else begin
            row_nxt = row_r + RIW'(1);
          end
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      pend_r     <= 1'b0;
      hold_r     <= 16'd0;
      debounce_r <= kmd_pkg::DebounceReset;
      dirty_r    <= '0;
      row_r      <= '0;
      for (int r = 0; r < ROWS; r++) begin
        raw_r[r]    <= '0;
        stable_r[r] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      hold_r  <= hold_nxt;
      dirty_r <= dirty_nxt;
      row_r   <= row_nxt;
      if (cfg_valid && cfg_ready) begin
        debounce_r <= cfg_data;
      end
      if (raw_we) begin
        raw_r[ridx] <= cols;
      end
      if (stable_we) begin
        stable_r[row_r] <= raw_r[row_r];
      end
    end
  end

endmodule

// ===== rtl/core/kmd_queue.sv =====
// Short queue of changed rows between the front and back parts.
module kmd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_full,
  input  kmd_pkg::row_entry_t  push_data,
  output logic                 pop_valid,
  input  logic                 pop_take,
  output kmd_pkg::row_entry_t  pop_data
);

  localparam int Depth = kmd_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  kmd_pkg::row_entry_t slot_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;
  logic                do_push, do_pop;

  assign push_full = (count_r == CntW'(Depth));
  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_take && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/kmd_back.sv =====
// Back part: turns each queued row into one key event per changed column.
module kmd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_take,
  input  kmd_pkg::row_entry_t  pop_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kmd_pkg::out_item_t   out_data
);

  logic                 cur_valid_r;
  kmd_pkg::row_entry_t  cur_r;
  logic                 out_valid_r;
  kmd_pkg::out_item_t   out_data_r;

  kmd_pkg::col_idx_t    col;
  kmd_pkg::col_vec_t    rem;
  logic                 emit;

  // Lowest changed column of the current row.
  always_comb begin
    col = '0;
    for (int c = kmd_pkg::MaxCols - 1; c >= 0; c--) begin
      if (cur_r.diff[c]) begin
        col = kmd_pkg::col_idx_t'(c);
      end
    end
  end

  assign rem       = cur_r.diff & ~(kmd_pkg::col_vec_t'(1) << col);
  assign emit      = cur_valid_r && (!out_valid_r || !out_stall);
  assign pop_take  = !cur_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.event_row    <= cur_r.row;
      out_data_r.event_column <= col;
      out_data_r.pressed      <= cur_r.level[col];
      out_data_r.last         <= cur_r.last_row && (rem == '0);
    end
    if (emit) begin
      cur_r.diff <= rem;
    end else if (!cur_valid_r && pop_valid) begin
      cur_r <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (emit) begin
        cur_valid_r <= (rem != '0);
      end else if (!cur_valid_r && pop_valid) begin
        cur_valid_r <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/key_matrix_debounce_events.sv =====
// Top level of the key matrix debouncer that reports key events.
//
// Each input beat is either a row sample (a row index with its decoded
// column levels) or a one millisecond tick. A sample that differs from the
// stored raw copy of its row replaces it and reloads the hold countdown from
// the debounce register; a tick counts the hold down, stopping at zero. When
// the countdown is at zero with a change pending, the raw matrix is committed
// as the stable matrix and one output beat is sent for every key that
// changed, rows ascending and columns ascending within a row, with last set
// on the final beat of the commit. Samples for rows at or above ROWS are
// ignored and column bits at or above COLS read as zero. An input beat that
// does not commit is taken without a stall and the next can follow at once. A
// commit holds the input stalled while the front part finds the changed rows
// and then walks every row, longer while the two-entry row queue is full.
// The back part sends one event per cycle while the output side does not
// stall, and it loads each changed row from the queue before sending its
// events, so the rate is set by the back part and by how fast the output
// side takes beats. An output register parts the result side from the input
// side. The debounce register is written through the cfg port, which is
// always ready; write it only while no commit is in flight.
module key_matrix_debounce_events #(
  parameter int ROWS = kmd_pkg::DefRows,
  parameter int COLS = kmd_pkg::DefCols
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kmd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kmd_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  // Row entries travel from the front part to the back part through the queue.
  logic                 push_valid;
  logic                 push_full;
  kmd_pkg::row_entry_t  push_data;
  logic                 pop_valid;
  logic                 pop_take;
  kmd_pkg::row_entry_t  pop_data;

  kmd_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data)
  );

  kmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_take   (pop_take),
    .pop_data   (pop_data)
  );

  kmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_take   (pop_take),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== test/key_event_checker.sv =====
// Checker that predicts the key events of the debouncer and compares them with its output.
module key_event_checker #(
  parameter int ROWS = kmd_pkg::DefRows,
  parameter int COLS = kmd_pkg::DefCols
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  kmd_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  kmd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 events_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import kmd_pkg::*;

  localparam col_vec_t ColMask = col_vec_t'((1 << COLS) - 1);

  col_vec_t       raw_level    [MaxRows];
  col_vec_t       stable_level [MaxRows];
  logic           change_pending;
  logic [DbW-1:0] hold_left;
  logic [DbW-1:0] debounce_setting;
  out_item_t      key_events_due [$];
  int             fail_total = 0;

  // Copies the raw matrix to the stable one and queues one event per changed key.
  task automatic commit_matrix();
    col_vec_t  diff;
    int        final_row;
    int        final_col;
    out_item_t key_event;
    final_row = -1;
    final_col = -1;
    for (int r = 0; r < ROWS; r++) begin
      diff = (raw_level[r] ^ stable_level[r]) & ColMask;
      for (int c = 0; c < COLS; c++) begin
        if (diff[c]) begin
          final_row = r;
          final_col = c;
        end
      end
    end
    for (int r = 0; r < ROWS; r++) begin
      diff = (raw_level[r] ^ stable_level[r]) & ColMask;
      for (int c = 0; c < COLS; c++) begin
        if (diff[c]) begin
          key_event.event_row    = row_idx_t'(r);
          key_event.event_column = col_idx_t'(c);
          key_event.pressed      = raw_level[r][c];
          key_event.last         = (r == final_row) && (c == final_col);
          key_events_due.push_back(key_event);
        end
      end
      stable_level[r] = raw_level[r];
    end
    change_pending = 1'b0;
  endtask

  task automatic predict_key_events(input in_item_t beat);
    col_vec_t levels;
    levels = beat.column_bits & ColMask;
    if (beat.kind == KindSample) begin
      if (int'(beat.row_index) < ROWS && raw_level[beat.row_index] != levels) begin
        raw_level[beat.row_index] = levels;
        change_pending            = 1'b1;
        hold_left                 = debounce_setting;
      end
    end else if (hold_left != '0) begin
      hold_left = hold_left - DbW'(1);
    end
    if (change_pending && hold_left == '0) commit_matrix();
  endtask

  task automatic check_key_event(input out_item_t seen);
    out_item_t want;
    if (key_events_due.size() == 0) begin
      $error("key event row %0d column %0d arrived with none expected",
             seen.event_row, seen.event_column);
      fail_total++;
    end else begin
      want = key_events_due.pop_front();
      if (seen.event_row !== want.event_row) begin
        $error("event_row: expected %0d, actual %0d", want.event_row, seen.event_row);
        fail_total++;
      end
      if (seen.event_column !== want.event_column) begin
        $error("event_column: expected %0d, actual %0d", want.event_column,
               seen.event_column);
        fail_total++;
      end
      if (seen.pressed !== want.pressed) begin
        $error("pressed: expected %0d, actual %0d", want.pressed, seen.pressed);
        fail_total++;
      end
      if (seen.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, seen.last);
        fail_total++;
      end
    end
  endtask

  // Results are taken before inputs so that an event can never match an
  // expectation created by the beat accepted at the same edge. A beat taken
  // at the edge that writes the debounce register still sees the old value.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MaxRows; r++) begin
        raw_level[r]    = '0;
        stable_level[r] = '0;
      end
      change_pending   = 1'b0;
      hold_left        = '0;
      debounce_setting = DebounceReset;
      key_events_due.delete();
    end else begin
      if (out_valid && !out_stall) check_key_event(out_data);
      if (in_valid && !in_stall) predict_key_events(in_data);
      if (cfg_valid && cfg_ready) debounce_setting = cfg_data;
    end
    mismatches         <= fail_total;
    events_outstanding <= key_events_due.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the testbench: drives scans and ticks into the key matrix debouncer and gives the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kmd_pkg::*;

  // A commit that finds nothing changed still walks every row, so a quiet
  // stretch lets it finish before the debounce register is touched.
  localparam int SettleCycles = 2 * MaxRows + 14;
  localparam int DrainLimit   = 100000;

  typedef enum int {
    StallNone,
    StallRandom,
    StallPeriodic,
    StallHeavy
  } stall_mode_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;
  int          mismatches;
  int          events_outstanding;

  // Sender burst state and the key levels that the scans present.
  int          burst_left = 0;
  int          items_sent = 0;
  col_vec_t    key_level [MaxRows];

  // Receiver stall pattern state.
  stall_mode_t stall_mode      = StallNone;
  int          stall_mode_left = 0;
  int          stall_phase     = 0;

  key_matrix_debounce_events u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  key_event_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data            (in_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data           (out_data),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .events_outstanding (events_outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // The receiver switches between a few stall styles every so often: none at
  // all, sparse random stalls, a fixed duty cycle, and heavy random stalls.
  // The periodic style slides against the event rate so that stalls land on
  // every position within a commit.
  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      <= stall_mode_t'($urandom_range(0, 3));
      stall_mode_left <= $urandom_range(20, 150);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    stall_phase <= (stall_phase + 1) % 7;
    case (stall_mode)
      StallNone: begin
        out_stall <= 1'b0;
      end
      StallRandom: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      StallPeriodic: begin
        out_stall <= (stall_phase < 3);
      end
      default: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // Sends one input beat and returns at the edge that accepts it. Beats come
  // in bursts of random length; between bursts valid drops for a random gap.
  // Once a burst ends there is sometimes no gap at all, and now and then a
  // long burst gives a stretch without any idling on the input side.
  task automatic send_beat(input logic kind, input int row, input col_vec_t cols);
    in_item_t beat;
    int       gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    beat.kind        = kind;
    beat.row_index   = row_idx_t'(row);
    beat.column_bits = cols;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Ticks carry don't-care row and column fields; fill them with noise.
  task automatic send_tick();
    send_beat(KindTick, $urandom_range(0, 7), col_vec_t'($urandom));
  endtask

  // Stops the input, waits until every predicted event has come out and then
  // gives a commit with no events time to finish its row walk.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid   <= 1'b0;
    burst_left = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (events_outstanding != 0 && waited < DrainLimit);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [15:0] ticks);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One pass over the matrix the way firmware scans it: every row sampled in
  // order, then a millisecond tick. Sometimes a few keys change first, and
  // sometimes one row reads a contact bounce that the next pass undoes.
  task automatic scan_matrix();
    int       bounce_row;
    int       changed_row;
    col_vec_t levels;
    if ($urandom_range(0, 3) == 0) begin
      changed_row = $urandom_range(0, MaxRows - 1);
      if ($urandom_range(0, 9) == 0) begin
        key_level[changed_row] = col_vec_t'($urandom);
      end else begin
        repeat ($urandom_range(1, 3))
          key_level[changed_row] ^= col_vec_t'(1 << $urandom_range(0, ColW - 1));
      end
    end
    bounce_row = ($urandom_range(0, 5) == 0) ? $urandom_range(0, MaxRows - 1) : -1;
    for (int r = 0; r < MaxRows; r++) begin
      levels = key_level[r];
      if (r == bounce_row) levels ^= col_vec_t'(1 << $urandom_range(0, ColW - 1));
      send_beat(KindSample, r, levels);
    end
    send_tick();
  endtask

  // Debounce setting and beat count of each random phase. The longest
  // setting is held only briefly since nothing commits under it.
  int unsigned phase_debounce [6] = '{2, 0, 65535, 1, 3, 4};
  int          phase_items    [6] = '{35, 30, 12, 30, 35, 38};

  initial begin
    int target;
    int pick;
    int noise_row;

    foreach (key_level[r]) key_level[r] = '0;

    // Synchronous reset, held low from the start and never again.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Under the reset setting of five ticks, a full row pressed commits on
    // the fifth tick as eight events; one more tick finds the countdown
    // already at zero and must stay silent.
    send_beat(KindSample, 0, 8'hFF);
    repeat (6) send_tick();

    // With no debounce every change commits at once: a single key on the
    // top row, a whole row released, and two complementary patterns on one row,
    // the second flipping every bit of it. Repeating the same levels changes nothing.
    settle();
    write_debounce(16'd0);
    send_beat(KindSample, 7, 8'h80);
    send_beat(KindSample, 0, 8'h00);
    send_beat(KindSample, 3, 8'h5A);
    send_beat(KindSample, 3, 8'hA5);
    send_beat(KindSample, 3, 8'hA5);

    // A key that goes down and comes back up before the hold runs out: the
    // commit sees the raw matrix equal to the stable one and sends nothing.
    // After that, changes in three rows commit together, with last on the
    // final key of the highest row.
    settle();
    write_debounce(16'd2);
    send_beat(KindSample, 5, 8'h01);
    send_beat(KindSample, 5, 8'h00);
    repeat (2) send_tick();
    send_beat(KindSample, 1, 8'h0F);
    send_beat(KindSample, 2, 8'hF0);
    send_beat(KindSample, 7, 8'h00);
    repeat (2) send_tick();

    // The longest hold: a change stays pending and the countdown is left
    // high when the next phase starts.
    settle();
    write_debounce(16'hFFFF);
    send_beat(KindSample, 4, 8'hFF);
    send_tick();

    // Random phases: mostly full matrix scans, with tick bursts to let held
    // changes commit and some glitches mixed in, either a random row value
    // or a flicker that is undone at once.
    phase_debounce[5] = $urandom_range(2, 6);
    foreach (phase_debounce[p]) begin
      settle();
      write_debounce(16'(phase_debounce[p]));
      target = items_sent + phase_items[p];
      while (items_sent < target) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          scan_matrix();
        end else if (pick < 8) begin
          repeat ($urandom_range(1, 6)) send_tick();
        end else begin
          noise_row = $urandom_range(0, MaxRows - 1);
          if ($urandom_range(0, 1) == 0) begin
            send_beat(KindSample, noise_row, col_vec_t'($urandom));
          end else begin
            send_beat(KindSample, noise_row,
                      key_level[noise_row] ^ col_vec_t'(1 << $urandom_range(0, ColW - 1)));
            send_beat(KindSample, noise_row, key_level[noise_row]);
          end
        end
      end
    end

    settle();
    if (mismatches == 0 && events_outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // The slowest correct run is about two hundred beats, each at worst
  // committing the whole matrix while the receiver stalls most beats, plus
  // input gaps and settling: well within the time limit below.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/kmd_pkg.sv
rtl/core/kmd_front.sv
rtl/core/kmd_queue.sv
rtl/core/kmd_back.sv
rtl/core/key_matrix_debounce_events.sv
test/key_event_checker.sv
test/testbench.sv
